FILE: hdl/int_to_grouped_decimal_text_assert.svh
// Assertion macros shared by the grouped decimal text block.
`ifndef INT_TO_GROUPED_DECIMAL_TEXT_ASSERT_SVH
`define INT_TO_GROUPED_DECIMAL_TEXT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ITGDT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ITGDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITGDT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ITGDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/itgdt_pkg.sv
// Shared types and constants of the grouped decimal text block.
package itgdt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_WIDTH        = 32;
    localparam int CHAR_WIDTH      = 7;

    // Long division by ten runs over chunks of this many bits.
    localparam int CHUNK_W     = 16;
    localparam int PART_W      = CHUNK_W + 4;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 21'd1677722;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] CH_COMMA = 7'd44;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 7'd45;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] value;
    } number_item_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last;
    } text_item_t;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } div_status_t;

    typedef struct packed {
        logic                  en;
        logic [CHAR_WIDTH-1:0] ch;
    } buf_wr_t;

endpackage

FILE: hdl/itgdt_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
interface itgdt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/itgdt_div10.sv
// Iterative divide-by-ten unit working one chunk of the dividend per cycle.
`include "int_to_grouped_decimal_text_assert.svh"

module itgdt_div10 #(
    parameter int VALUE_WIDTH = itgdt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      operand,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output itgdt_pkg::div_status_t      status
);
    localparam int CHUNKS = (VALUE_WIDTH + itgdt_pkg::CHUNK_W - 1) / itgdt_pkg::CHUNK_W;
    localparam int PAD_W  = CHUNKS * itgdt_pkg::CHUNK_W;
    localparam int CNT_W  = $clog2(CHUNKS + 1);
    localparam int PROD_W = itgdt_pkg::PART_W + itgdt_pkg::RECIP_W;

    logic [PAD_W-1:0] work_reg, work_next;
    logic [3:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [itgdt_pkg::PART_W-1:0]  part;
    logic [PROD_W-1:0]             prod;
    logic [itgdt_pkg::CHUNK_W-1:0] q_chunk;
    logic [itgdt_pkg::PART_W-1:0]  q_times_ten;
    logic [itgdt_pkg::PART_W-1:0]  r_full;

    always_comb
    begin
        part        = {rem_reg, work_reg[PAD_W-1 -: itgdt_pkg::CHUNK_W]};
        prod        = PROD_W'(part) * PROD_W'(itgdt_pkg::RECIP_TEN);
        q_chunk     = prod[itgdt_pkg::RECIP_SHIFT +: itgdt_pkg::CHUNK_W];
        q_times_ten = (itgdt_pkg::PART_W'(q_chunk) << 3) + (itgdt_pkg::PART_W'(q_chunk) << 1);
        r_full      = part - q_times_ten;
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = PAD_W'(operand);
            rem_next  = 4'd0;
            cnt_next  = CNT_W'(CHUNKS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = (work_reg << itgdt_pkg::CHUNK_W) | PAD_W'(q_chunk);
            rem_next  = r_full[3:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign quotient     = work_reg[VALUE_WIDTH-1:0];
    assign status.done  = done_reg;
    assign status.digit = rem_reg;

    `ITGDT_ASSERT_IMPLIES(a_start_when_free, clk, rst_n, start, !busy_reg, "divider restarted while busy")
    `ITGDT_ASSERT_IMPLIES(a_digit_range, clk, rst_n, done_reg, rem_reg <= 4'd9, "divider remainder above nine")
    `ITGDT_ASSERT_NEXT(a_busy_ends, clk, rst_n, busy_reg && cnt_reg == '0 && !start, done_reg && !busy_reg, "divider did not finish")

endmodule

FILE: hdl/itgdt_text_buf.sv
// Character store that holds the text least significant character first.
module itgdt_text_buf #(
    parameter int DEPTH = 14
) (
    input  logic                                 clk,
    input  itgdt_pkg::buf_wr_t                   wr,
    input  logic [$clog2(DEPTH)-1:0]             wr_addr,
    input  logic [$clog2(DEPTH)-1:0]             rd_addr,
    output logic [itgdt_pkg::CHAR_WIDTH-1:0]     rd_ch
);
    logic [itgdt_pkg::CHAR_WIDTH-1:0] mem_reg [DEPTH];
    logic [itgdt_pkg::CHAR_WIDTH-1:0] rd_ch_reg;

    // A read of the entry being written returns the new character.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr_addr] <= wr.ch;
        end
        if (wr.en && wr_addr == rd_addr)
        begin
            rd_ch_reg <= wr.ch;
        end
        else
        begin
            rd_ch_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_ch = rd_ch_reg;

endmodule

FILE: hdl/int_to_grouped_decimal_text.sv
// Top level: signed integer to grouped decimal ASCII text.
//
// The number channel takes one signed 32-bit item; its low VALUE_WIDTH bits are
// read as two's complement. The text channel then gives one item per character,
// most significant first: an optional minus sign, the digits, and a comma between
// each group of three digits counted from the right. The final character of a
// number has last set. Zero gives the single character '0'.
// Each digit is made by a shared divide-by-ten unit that works 16 bits of the
// magnitude per cycle; the digit is then written to the text store in its own
// step. Each comma and the minus sign are written in a step of their own, and
// then every character is shown on the text channel, most significant first.
// The number channel is ready only while no item is in work, and the next item is
// taken in the cycle after the last character is delivered.
// When the receiver holds ready low, the current character stays on the channel
// and the block waits. Reset returns the block to idle and drops any item in work.
`include "int_to_grouped_decimal_text_assert.svh"

module int_to_grouped_decimal_text #(
    parameter int VALUE_WIDTH = itgdt_pkg::VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    itgdt_stream_if.sink  number,
    itgdt_stream_if.source text
);
    localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int DEPTH  = DIGITS + (DIGITS - 1) / 3 + 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_PUT   = 3'd2;
    localparam logic [2:0] ST_MINUS = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [1:0]       grp_reg, grp_next;
    logic             neg_reg, neg_next;

    logic [VALUE_WIDTH-1:0]  raw;
    logic [VALUE_WIDTH-1:0]  abs_val;
    logic                    div_start;
    logic [VALUE_WIDTH-1:0]  div_operand;
    logic [VALUE_WIDTH-1:0]  div_quotient;
    itgdt_pkg::div_status_t  div_status;
    itgdt_pkg::buf_wr_t      wr;
    logic [itgdt_pkg::CHAR_WIDTH-1:0] rd_ch;

    assign raw     = VALUE_WIDTH'($unsigned(number.payload.value));
    assign abs_val = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

    itgdt_div10 #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .operand  (div_operand),
        .quotient (div_quotient),
        .status   (div_status)
    );

    itgdt_text_buf #(
        .DEPTH (DEPTH)
    ) u_text_buf (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (ptr_reg[IDX_W-1:0]),
        .rd_addr (IDX_W'(ptr_next - PTR_W'(1))),
        .rd_ch   (rd_ch)
    );

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        grp_next    = grp_reg;
        neg_next    = neg_reg;
        div_start   = 1'b0;
        div_operand = abs_val;
        wr.en       = 1'b0;
        wr.ch       = itgdt_pkg::CH_COMMA;
        case (state_reg)
            ST_IDLE:
            begin
                if (number.valid)
                begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                    ptr_next   = '0;
                    grp_next   = 2'd0;
                    neg_next   = raw[VALUE_WIDTH-1];
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                wr.en    = 1'b1;
                ptr_next = ptr_reg + PTR_W'(1);
                if (grp_reg == 2'd3)
                begin
                    wr.ch    = itgdt_pkg::CH_COMMA;
                    grp_next = 2'd0;
                end
                else
                begin
                    wr.ch    = itgdt_pkg::CH_ZERO + itgdt_pkg::CHAR_WIDTH'(div_status.digit);
                    grp_next = grp_reg + 2'd1;
                    if (div_quotient == '0)
                    begin
                        state_next = neg_reg ? ST_MINUS : ST_OUT;
                    end
                    else
                    begin
                        div_start   = 1'b1;
                        div_operand = div_quotient;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_MINUS:
            begin
                wr.en      = 1'b1;
                wr.ch      = itgdt_pkg::CH_MINUS;
                ptr_next   = ptr_reg + PTR_W'(1);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (text.ready)
                begin
                    ptr_next = ptr_reg - PTR_W'(1);
                    if (ptr_reg == PTR_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            grp_reg   <= 2'd0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            grp_reg   <= grp_next;
            neg_reg   <= neg_next;
        end
    end

    assign number.ready           = (state_reg == ST_IDLE);
    assign text.valid             = (state_reg == ST_OUT);
    assign text.payload.character = rd_ch;
    assign text.payload.last      = (ptr_reg == PTR_W'(1));

    `ITGDT_ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_status.done, state_reg == ST_DIV, "divider finished outside wait")
    `ITGDT_ASSERT_IMPLIES(a_wr_in_range, clk, rst_n, wr.en, ptr_reg < PTR_W'(DEPTH), "text store overflow")
    `ITGDT_ASSERT_IMPLIES(a_out_nonempty, clk, rst_n, text.valid, ptr_reg != '0, "character shown from empty store")
    `ITGDT_ASSERT_NEXT(a_last_to_idle, clk, rst_n, text.valid && text.ready && text.payload.last, number.ready, "no return to idle after last")

endmodule

FILE: bench/tb_int_to_grouped_decimal_text.sv
// Self-checking testbench for the signed integer to grouped decimal text block.
module tb_int_to_grouped_decimal_text;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_NUMBERS = 350;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 64;

    class grouped_text_scoreboard;
        itgdt_pkg::text_item_t pending_chars[$];
        int unsigned           failures;

        function new();
            failures = 0;
        endfunction

        function void note_number(logic signed [itgdt_pkg::IN_WIDTH-1:0] value);
            logic [itgdt_pkg::IN_WIDTH-1:0]   mag;
            logic [itgdt_pkg::CHAR_WIDTH-1:0] reversed[$];
            logic [3:0]                       digit;
            int unsigned                      group_len;
            itgdt_pkg::text_item_t            item;

            mag = value[itgdt_pkg::IN_WIDTH-1] ? (~$unsigned(value) + 1'b1) : $unsigned(value);
            group_len = 0;
            do
            begin
                if (group_len == 3)
                begin
                    reversed = {reversed, itgdt_pkg::CH_COMMA};
                    group_len = 0;
                end
                digit = 4'(mag % 10);
                reversed = {reversed, itgdt_pkg::CHAR_WIDTH'(itgdt_pkg::CH_ZERO + digit)};
                group_len++;
                mag = mag / 10;
            end
            while (mag != 0);
            if (value[itgdt_pkg::IN_WIDTH-1])
            begin
                reversed = {reversed, itgdt_pkg::CH_MINUS};
            end
            for (int i = reversed.size() - 1; i >= 0; i--)
            begin
                item.character = reversed[i];
                item.last      = (i == 0);
                pending_chars = {pending_chars, item};
            end
        endfunction

        function void check_char(itgdt_pkg::text_item_t got);
            itgdt_pkg::text_item_t want;

            if (pending_chars.size() == 0)
            begin
                $error("character: expected none, actual %0d (last %0d)",
                       got.character, got.last);
                failures++;
                return;
            end
            want = pending_chars.pop_front();
            if (got.character !== want.character)
            begin
                $error("character: expected %0d, actual %0d", want.character, got.character);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned quiet_cycles;
    grouped_text_scoreboard sb;

    itgdt_stream_if #(.payload_t(itgdt_pkg::number_item_t)) number_ch ();
    itgdt_stream_if #(.payload_t(itgdt_pkg::text_item_t))   text_ch ();

    int_to_grouped_decimal_text dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    always
    begin
        #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            sb.check_char(text_ch.payload);
        end
        text_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((number_ch.valid && number_ch.ready) || (text_ch.valid && text_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_number(logic signed [itgdt_pkg::IN_WIDTH-1:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            number_ch.valid <= 1'b0;
            @(posedge clk);
        end
        number_ch.valid         <= 1'b1;
        number_ch.payload.value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!number_ch.ready);
        sb.note_number(value);
    endtask

    task automatic wait_drained();
        number_ch.valid <= 1'b0;
        while (sb.pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [itgdt_pkg::IN_WIDTH-1:0] random_number();
        logic [itgdt_pkg::IN_WIDTH-1:0] v;
        logic [itgdt_pkg::IN_WIDTH-1:0] pow;

        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(31);
            2:
            begin
                pow = 1;
                repeat ($urandom_range(9))
                begin
                    pow = pow * 10;
                end
                v = pow + $urandom_range(2) - 1;
            end
            default: v = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(1))
        begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    initial
    begin
        logic signed [itgdt_pkg::IN_WIDTH-1:0] directed[$];

        clk = 1'b0;
        sb = new();
        quiet_cycles = 0;
        src_idle_pct = 27;
        sink_idle_pct = 27;
        rst_n = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.payload = '0;
        text_ch.ready = 1'b0;
        repeat (8)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{0, 1, -1, 9, 10, 99, 100, 999, 1000, -1000, 9999, 12345, -123456,
                     999999, 1000000, -999999, 2147483647, -2147483647, 32'h8000_0000,
                     1000000000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_0000};
        foreach (directed[i])
        begin
            send_number(directed[i]);
        end

        for (int n = 0; n < RANDOM_NUMBERS; n++)
        begin
            if (n == 100)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            else if (n == 180)
            begin
                src_idle_pct = 27;
                sink_idle_pct = 27;
            end
            if (n == 250)
            begin
                wait_drained();
            end
            send_number(random_number());
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (sb.failures == 0 && sb.pending_chars.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
